/* sv/dcs_pkg.sv */
// Types and constants shared by the display coprocessor sequencer files.
`default_nettype none

package dcs_pkg;

  // Fixed field widths of the channels and the configuration port.
  localparam int FETCH_ADDR_W = 19;
  localparam int WORD_W       = 16;
  localparam int OFFSET_W     = 9;
  localparam int CMD_W        = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 19;

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_SLOT           = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART_FIRST  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART_SECOND = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STOP           = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_DANGER_ENABLE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIST_START_FIRST  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIST_START_SECOND = 2'd2;

  // Sequencer phases.
  localparam logic [1:0] PH_STOPPED      = 2'd0;
  localparam logic [1:0] PH_WAITING      = 2'd1;
  localparam logic [1:0] PH_FETCH_FIRST  = 2'd2;
  localparam logic [1:0] PH_FETCH_SECOND = 2'd3;

  // Instruction decode constants.
  localparam logic [WORD_W-1:0] OFFSET_MASK      = 16'h01fe;
  localparam logic [WORD_W-1:0] MIN_OFFSET       = 16'h0010;
  localparam logic [WORD_W-1:0] MIN_SAFE_OFFSET  = 16'h0020;
  localparam logic [WORD_W-1:0] CMP_MASK_FIXED   = 16'h8001;
  localparam logic [WORD_W-1:0] CMP_MASK_SELECT  = 16'h7ffe;

  typedef struct packed {
    logic [1:0]        phase;
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] compare_mask;
    logic              skip_pending;
  } dcs_state_t;

  typedef struct packed {
    logic                slot_taken;
    logic                reg_write_valid;
    logic [OFFSET_W-1:0] reg_write_offset;
    logic [WORD_W-1:0]   reg_write_data;
    logic                halted;
  } dcs_result_t;

endpackage

`default_nettype wire

/* sv/dcs_if.sv */
// Valid/ready channel interfaces for the item input and the result output.
`default_nettype none

interface dcs_in_if;
  import dcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [WORD_W-1:0] beam_position;
  logic [WORD_W-1:0] fetch_word;

  modport source (output valid, command, beam_position, fetch_word, input ready);
  modport sink   (input valid, command, beam_position, fetch_word, output ready);
endinterface

interface dcs_out_if;
  import dcs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    slot_taken;
  logic                    reg_write_valid;
  logic [OFFSET_W-1:0]     reg_write_offset;
  logic [WORD_W-1:0]       reg_write_data;
  logic [FETCH_ADDR_W-1:0] fetch_address;
  logic                    halted;

  modport source (output valid, slot_taken, reg_write_valid, reg_write_offset,
                  reg_write_data, fetch_address, halted, input ready);
  modport sink   (input valid, slot_taken, reg_write_valid, reg_write_offset,
                  reg_write_data, fetch_address, halted, output ready);
endinterface

`default_nettype wire

/* sv/dcs_exec.sv */
// Combinational step of the sequencer: one beat against the current state.
`default_nettype none

module dcs_exec #(
  parameter int ADDR_BITS = 19
) (
  input  wire logic [dcs_pkg::CMD_W-1:0]        command,
  input  wire logic [dcs_pkg::WORD_W-1:0]       beam_position,
  input  wire logic [dcs_pkg::WORD_W-1:0]       fetch_word,
  input  wire logic                             danger_enable,
  input  wire logic [dcs_pkg::CFG_DATA_W-1:0]   list_start_first,
  input  wire logic [dcs_pkg::CFG_DATA_W-1:0]   list_start_second,
  input  wire dcs_pkg::dcs_state_t              state_cur,
  input  wire logic [ADDR_BITS-1:0]             list_address,
  output dcs_pkg::dcs_state_t                   state_nxt,
  output logic [ADDR_BITS-1:0]                  list_address_nxt,
  output dcs_pkg::dcs_result_t                  result
);
  import dcs_pkg::*;

  logic [ADDR_BITS-1:0] addr_inc;
  logic [WORD_W-1:0]    move_offset;
  logic [WORD_W-1:0]    new_mask;
  logic [WORD_W-1:0]    new_target;
  logic                 wait_done;
  logic                 new_reached;
  logic                 move_illegal;

  assign addr_inc     = list_address + ADDR_BITS'(1);
  assign move_offset  = state_cur.first_word & OFFSET_MASK;
  assign move_illegal = (move_offset < MIN_OFFSET) ||
                        ((move_offset < MIN_SAFE_OFFSET) && !danger_enable);
  assign wait_done    = (beam_position & state_cur.compare_mask) >= state_cur.first_word;
  assign new_mask     = CMP_MASK_FIXED | (fetch_word & CMP_MASK_SELECT);
  assign new_target   = state_cur.first_word & new_mask;
  assign new_reached  = (beam_position & new_mask) >= new_target;

  always_comb begin
    state_nxt        = state_cur;
    list_address_nxt = list_address;
    result           = '0;

    unique case (command)
      CMD_RESTART_FIRST: begin
        list_address_nxt = ADDR_BITS'(list_start_first);
        state_nxt.phase  = PH_FETCH_FIRST;
      end
      CMD_RESTART_SECOND: begin
        list_address_nxt = ADDR_BITS'(list_start_second);
        state_nxt.phase  = PH_FETCH_FIRST;
      end
      CMD_STOP: begin
        state_nxt.phase = PH_STOPPED;
      end
      CMD_SLOT: begin
        unique case (state_cur.phase)
          PH_STOPPED: begin
          end
          PH_WAITING: begin
            if (wait_done) begin
              state_nxt.phase = PH_FETCH_FIRST;
            end
          end
          PH_FETCH_FIRST: begin
            state_nxt.first_word = fetch_word;
            list_address_nxt     = addr_inc;
            state_nxt.phase      = PH_FETCH_SECOND;
            result.slot_taken    = 1'b1;
          end
          PH_FETCH_SECOND: begin
            state_nxt.skip_pending = 1'b0;
            list_address_nxt       = addr_inc;
            result.slot_taken      = 1'b1;
            state_nxt.phase        = PH_FETCH_FIRST;
            if (!state_cur.first_word[0]) begin
              // A pending skip swallows the move, legal or not.
              if (!state_cur.skip_pending) begin
                state_nxt.first_word = move_offset;
                if (move_illegal) begin
                  state_nxt.phase = PH_STOPPED;
                end else begin
                  result.reg_write_valid  = 1'b1;
                  result.reg_write_offset = move_offset[OFFSET_W-1:0];
                  result.reg_write_data   = fetch_word;
                end
              end
            end else begin
              state_nxt.compare_mask = new_mask;
              state_nxt.first_word   = new_target;
              if (!fetch_word[0]) begin
                state_nxt.phase = PH_WAITING;
              end else begin
                state_nxt.skip_pending = new_reached;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    result.halted = (state_nxt.phase == PH_STOPPED);
  end

endmodule

`default_nettype wire

/* sv/display_coprocessor_sequencer.sv */
// Top level of the display list coprocessor sequencer (move, wait, skip).
//
//   Channel | Direction | Fields
//   in_ch   | sink      | command, beam_position, fetch_word
//   out_ch  | source    | slot_taken, reg_write_valid, reg_write_offset,
//           |           | reg_write_data, fetch_address, halted
//   cfg_*   | write     | cfg_we, cfg_index, cfg_wdata
//
// Each beat lands in an input register, is executed combinationally and its
// result is held in an output register before it is presented; a new beat can
// be taken every cycle while the output register is not stalled.
// Reset is synchronous: the sequencer starts stopped at list address zero.
// A stalled output still lets one more beat enter the input register.
`default_nettype none

module display_coprocessor_sequencer #(
  parameter int ADDR_BITS = 19
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  dcs_in_if.sink                                  in_ch,
  dcs_out_if.source                               out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [dcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [dcs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dcs_pkg::*;

  // Configuration registers.
  logic                  danger_enable_r;
  logic [CFG_DATA_W-1:0] list_start_first_r;
  logic [CFG_DATA_W-1:0] list_start_second_r;

  // Input register.
  logic              in_valid_r;
  logic [CMD_W-1:0]  in_command_r;
  logic [WORD_W-1:0] in_beam_r;
  logic [WORD_W-1:0] in_word_r;

  // Sequencer state.
  dcs_state_t           state_r;
  dcs_state_t           state_nxt;
  logic [ADDR_BITS-1:0] list_address_r;
  logic [ADDR_BITS-1:0] list_address_nxt;

  // Output register.
  logic                    out_valid_r;
  dcs_result_t             out_result_r;
  dcs_result_t             result;
  logic [FETCH_ADDR_W-1:0] out_fetch_address_r;

  logic advance;
  logic in_accept;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || advance;
  assign in_accept   = in_ch.valid && in_ch.ready;

  dcs_exec #(
    .ADDR_BITS (ADDR_BITS)
  ) u_exec (
    .command           (in_command_r),
    .beam_position     (in_beam_r),
    .fetch_word        (in_word_r),
    .danger_enable     (danger_enable_r),
    .list_start_first  (list_start_first_r),
    .list_start_second (list_start_second_r),
    .state_cur         (state_r),
    .list_address      (list_address_r),
    .state_nxt         (state_nxt),
    .list_address_nxt  (list_address_nxt),
    .result            (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      danger_enable_r     <= 1'b0;
      list_start_first_r  <= '0;
      list_start_second_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DANGER_ENABLE:     danger_enable_r     <= cfg_wdata[0];
        CFG_LIST_START_FIRST:  list_start_first_r  <= cfg_wdata;
        CFG_LIST_START_SECOND: list_start_second_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_command_r <= in_ch.command;
      in_beam_r    <= in_ch.beam_position;
      in_word_r    <= in_ch.fetch_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= '{phase: PH_STOPPED, first_word: '0, compare_mask: '0,
                          skip_pending: 1'b0};
      list_address_r <= '0;
      out_valid_r    <= 1'b0;
    end else if (in_valid_r && advance) begin
      state_r        <= state_nxt;
      list_address_r <= list_address_nxt;
      out_valid_r    <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && advance) begin
      out_result_r        <= result;
      out_fetch_address_r <= FETCH_ADDR_W'(list_address_nxt);
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.slot_taken       = out_result_r.slot_taken;
  assign out_ch.reg_write_valid  = out_result_r.reg_write_valid;
  assign out_ch.reg_write_offset = out_result_r.reg_write_offset;
  assign out_ch.reg_write_data   = out_result_r.reg_write_data;
  assign out_ch.fetch_address    = out_fetch_address_r;
  assign out_ch.halted           = out_result_r.halted;

endmodule

`default_nettype wire
